// ===== src/rse_pkg.sv =====
// Shared types and constants for the ribbon strip expander.
// No dependencies.
package rse_pkg;

    localparam int MAX_VERTICES = 32768;
    localparam int COUNT_CAP    = (MAX_VERTICES < 65535) ? MAX_VERTICES : 65535;
    localparam int CNT_W        = 16;
    localparam int QUEUE_DEPTH  = 2;

    // one job for the back end: expand vertex p with tangent (nxt - prv)
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic        [31:0] width;
        logic        [31:0] u;
        logic               last;
        logic        [15:0] tri_cnt;
    } t_job;

endpackage

// ===== src/rse_front.sv =====
// Front end: holds the run context and issues one expansion job per vertex of a run of two or more vertices.
// Depends on rse_pkg.
module rse_front
    import rse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    input  logic [31:0] i_z,
    input  logic [31:0] i_w,
    input  logic [31:0] i_u,
    input  logic        i_last,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_TAIL = 2'd1;

    logic [1:0]        r_state;
    logic signed [31:0] r_prv [3];
    logic signed [31:0] r_hld [3];
    logic [31:0]       r_hw, r_hu;
    logic              r_hv, r_hp;
    logic [CNT_W-1:0]  r_cnt;
    t_job              r_tail;
    logic              acc;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W:0]    tri_w;
    logic signed [31:0] cur [3];
    logic signed [31:0] prv [3];

    assign cur[0] = i_x;
    assign cur[1] = i_y;
    assign cur[2] = i_z;
    assign o_ready = (r_state == ST_RUN) && (!r_hv || i_job_ready);
    assign acc = i_valid && o_ready;
    assign cnt_inc = (r_cnt < CNT_W'(COUNT_CAP)) ? r_cnt + 1'b1 : r_cnt;
    assign tri_w = ({1'b0, cnt_inc} - 1'b1) << 1;

    always_comb begin
        for (int i = 0; i < 3; i++) prv[i] = r_hp ? r_prv[i] : r_hld[i];
        if (r_state == ST_TAIL) begin
            o_job_valid = 1'b1;
            o_job = r_tail;
        end else begin
            o_job_valid = i_valid && r_hv;
            o_job.px = r_hld[0];
            o_job.py = r_hld[1];
            o_job.pz = r_hld[2];
            o_job.dx = 33'(cur[0]) - 33'(prv[0]);
            o_job.dy = 33'(cur[1]) - 33'(prv[1]);
            o_job.dz = 33'(cur[2]) - 33'(prv[2]);
            o_job.width = r_hw;
            o_job.u = r_hu;
            o_job.last = 1'b0;
            o_job.tri_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_hv <= 1'b0;
            r_hp <= 1'b0;
            r_cnt <= '0;
        end else if (r_state == ST_TAIL) begin
            if (i_job_ready) r_state <= ST_RUN;
        end else if (acc) begin
            if (!r_hv) begin
                if (!i_last) begin
                    r_hv <= 1'b1;
                    r_hp <= 1'b0;
                    r_cnt <= CNT_W'(1);
                    for (int i = 0; i < 3; i++) r_hld[i] <= cur[i];
                    r_hw <= i_w;
                    r_hu <= i_u;
                end
            end else if (i_last) begin
                r_hv <= 1'b0;
                r_hp <= 1'b0;
                r_cnt <= '0;
                r_state <= ST_TAIL;
                r_tail.px <= cur[0];
                r_tail.py <= cur[1];
                r_tail.pz <= cur[2];
                r_tail.dx <= 33'(cur[0]) - 33'(r_hld[0]);
                r_tail.dy <= 33'(cur[1]) - 33'(r_hld[1]);
                r_tail.dz <= 33'(cur[2]) - 33'(r_hld[2]);
                r_tail.width <= i_w;
                r_tail.u <= i_u;
                r_tail.last <= 1'b1;
                r_tail.tri_cnt <= (tri_w > 17'd65534) ? 16'd65534 : tri_w[15:0];
            end else begin
                r_hp <= 1'b1;
                r_cnt <= cnt_inc;
                for (int i = 0; i < 3; i++) begin
                    r_prv[i] <= r_hld[i];
                    r_hld[i] <= cur[i];
                end
                r_hw <= i_w;
                r_hu <= i_u;
            end
        end
    end

endmodule

// ===== src/rse_queue.sv =====
// Short job queue between the front and back ends.
// Depends on rse_pkg.
module rse_queue
    import rse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    t_job r_mem [QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_n;
    logic wr, rd;

    assign o_ready = r_n != 2'(QUEUE_DEPTH);
    assign o_valid = r_n != 2'd0;
    assign o_job = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_n <= r_n + 2'(wr) - 2'(rd);
        end
    end

endmodule

// ===== src/rse_back.sv =====
// Back end: normalizes the tangent (iterative sqrt and divide), then emits
// the minus and plus strip vertices. Depends on rse_pkg.
module rse_back
    import rse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_x,
    output logic [31:0] o_y,
    output logic [31:0] o_z,
    output logic [31:0] o_u,
    output logic        o_side,
    output logic        o_last,
    output logic [15:0] o_tri
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_DIVX = 4'd4;
    localparam logic [3:0] S_DIVZ = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_OUT0 = 4'd8;
    localparam logic [3:0] S_OUT1 = 4'd9;

    logic [3:0]  r_st;
    t_job        r_j;
    logic        r_nx, r_nz;
    logic [32:0] r_m [3];
    logic [1:0]  r_k;
    logic [63:0] r_s, r_rem, r_root;
    logic [5:0]  r_it;
    logic [63:0] r_num, r_quo;
    logic [31:0] r_tx, r_tz;
    logic [63:0] r_px, r_pz;
    logic signed [33:0] r_ox, r_oz;
    logic        r_zero;

    logic [32:0] mx;
    logic [63:0] trial, dtrial;
    logic        q_bit;
    logic [63:0] ox_m, oz_m;
    logic signed [33:0] xa, xb, za, zb;

    assign mx = (r_m[0] > r_m[1]) ? ((r_m[0] > r_m[2]) ? r_m[0] : r_m[2])
                                  : ((r_m[1] > r_m[2]) ? r_m[1] : r_m[2]);
    assign o_ready = r_st == S_IDLE;
    assign trial = r_root | (64'd1 << {r_it, 1'b0});
    // restoring division: remainder in r_rem, shifting numerator in
    assign dtrial = {r_rem[62:0], r_num[63]};
    assign q_bit = dtrial >= r_root;

    function automatic logic [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -34'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    assign ox_m = (r_px + 64'd1073741824) >> 31;
    assign oz_m = (r_pz + 64'd1073741824) >> 31;
    assign xa = 34'(r_j.px) - r_ox;
    assign xb = 34'(r_j.px) + r_ox;
    assign za = 34'(r_j.pz) - r_oz;
    assign zb = 34'(r_j.pz) + r_oz;

    assign o_valid = (r_st == S_OUT0) || (r_st == S_OUT1);
    assign o_x = sat((r_st == S_OUT1) ? xb : xa);
    assign o_y = r_j.py;
    assign o_z = sat((r_st == S_OUT1) ? zb : za);
    assign o_u = r_j.u;
    assign o_side = r_st == S_OUT1;
    assign o_last = (r_st == S_OUT1) && r_j.last;
    assign o_tri = (r_st == S_OUT1) ? r_j.tri_cnt : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_j <= i_job;
                    r_nx <= i_job.dx[32];
                    r_nz <= i_job.dz[32];
                    r_m[0] <= i_job.dx[32] ? 33'(-i_job.dx) : i_job.dx;
                    r_m[1] <= i_job.dy[32] ? 33'(-i_job.dy) : i_job.dy;
                    r_m[2] <= i_job.dz[32] ? 33'(-i_job.dz) : i_job.dz;
                    r_st <= S_NORM;
                end
                S_NORM: begin
                    // step one bit per cycle toward [2^30, 2^31)
                    if (mx == 33'd0) begin
                        r_zero <= 1'b1;
                        r_tx <= 32'd1 << 30;
                        r_tz <= '0;
                        r_st <= S_MUL;
                    end else if (mx[32:31] != 2'b00) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (!mx[30]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_zero <= 1'b0;
                        r_s <= '0;
                        r_k <= 2'd0;
                        r_st <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_s <= r_s + r_m[r_k][31:0] * r_m[r_k][31:0];
                    if (r_k == 2'd2) begin
                        r_rem <= '0;
                        r_root <= '0;
                        r_it <= 6'd31;
                        r_st <= S_SQRT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_SQRT: begin
                    if (r_s >= trial) begin
                        r_s <= r_s - trial;
                        r_root <= (r_root >> 1) | (64'd1 << {r_it, 1'b0});
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    if (r_it == 6'd0) begin
                        r_k <= 2'd0;
                        r_num <= ({31'd0, r_m[0]} << 30) + (r_root >> 2);
                        r_rem <= '0;
                        r_it <= 6'd63;
                        r_st <= S_DIVX;
                    end else begin
                        r_it <= r_it - 6'd1;
                    end
                end
                S_DIVX, S_DIVZ: begin
                    // r_root holds L here; one quotient bit per cycle
                    r_quo <= {r_quo[62:0], q_bit};
                    if (r_it != 6'd0) begin
                        r_rem <= q_bit ? dtrial - r_root : dtrial;
                        r_num <= r_num << 1;
                        r_it <= r_it - 6'd1;
                    end else if (r_st == S_DIVX) begin
                        r_tx <= {r_quo[30:0], q_bit};
                        r_num <= ({31'd0, r_m[2]} << 30) + (r_root >> 1);
                        r_rem <= '0;
                        r_it <= 6'd63;
                        r_st <= S_DIVZ;
                    end else begin
                        r_tz <= {r_quo[30:0], q_bit};
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_px <= r_tz * r_j.width;
                    r_pz <= r_tx * r_j.width;
                    r_st <= S_SUM;
                end
                S_SUM: begin
                    // ox follows +tz, oz follows -tx
                    r_ox <= (r_nz && !r_zero) ? -34'(ox_m) : 34'(ox_m);
                    r_oz <= (r_nx && !r_zero) ? 34'(oz_m) : -34'(oz_m);
                    r_st <= S_OUT0;
                end
                S_OUT0: if (i_ready) r_st <= S_OUT1;
                S_OUT1: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/ribbon_strip_expander.sv =====
// Top level of the ribbon strip expander: front end, job queue, back end.
// Depends on rse_pkg, rse_front, rse_queue, rse_back.
//
//  channel | dir | tdata (low bit up)                         | tuser | tlast
//  s_axis  | in  | pos_x, pos_y, pos_z, ribbon_width, tex_u    | -     | last_vertex
//  m_axis  | out | out_x, out_y, out_z, out_u, triangle_count  | side_v| last_of_run
//
// A job passes 1 to 31 normalize steps, 3 square steps, a 32-step square root
// and two 64-step restoring divisions before its two strip vertices go out; a
// zero tangent skips squares, root and divisions. The final vertex of a run
// adds a second job. Vertices are taken while the queue has room and no tail
// job is pending. Reset is synchronous, active low, and empties the run and
// queue. A stalled m_axis holds the current strip vertex and backs up the queue.
module ribbon_strip_expander
    import rse_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, ribbon_width, tex_u
    input  logic [159:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z, out_u, triangle_count
    output logic [143:0] m_axis_tdata,
    // side_v
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    t_job fq_job, qb_job;
    logic fq_v, fq_r, qb_v, qb_r;
    logic [31:0] ox, oy, oz, ou;
    logic [15:0] tri_cnt;

    rse_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_x(s_axis_tdata[31:0]), .i_y(s_axis_tdata[63:32]),
        .i_z(s_axis_tdata[95:64]), .i_w(s_axis_tdata[127:96]),
        .i_u(s_axis_tdata[159:128]), .i_last(s_axis_tlast),
        .o_job_valid(fq_v), .i_job_ready(fq_r), .o_job(fq_job)
    );

    rse_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(fq_v), .o_ready(fq_r), .i_job(fq_job),
        .o_valid(qb_v), .i_ready(qb_r), .o_job(qb_job)
    );

    rse_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(qb_v), .o_ready(qb_r), .i_job(qb_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_x(ox), .o_y(oy), .o_z(oz), .o_u(ou),
        .o_side(m_axis_tuser), .o_last(m_axis_tlast), .o_tri(tri_cnt)
    );

    assign m_axis_tdata = {tri_cnt, ou, oz, oy, ox};

endmodule
